FILE: src/lfoc_pkg.sv
package lfoc_pkg;

  // input command codes
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_LINE  = 3'd3,
    CMD_ECHO  = 3'd4
  } cmd_t;

  // motor drive codes
  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_BACK = 2'd2
  } drv_t;

  // remembered line side; code 3 is never written and acts as center
  typedef enum logic [1:0] {
    SIDE_CENTER = 2'd0,
    SIDE_LEFT   = 2'd1,
    SIDE_RIGHT  = 2'd2
  } side_t;

  // register indexes on the config bus (byte address = 4 * index)
  localparam logic [2:0] REG_OBSTACLE_CM = 3'd0;
  localparam logic [2:0] REG_GENTLE_MS   = 3'd1;
  localparam logic [2:0] REG_MEDIUM_MS   = 3'd2;
  localparam logic [2:0] REG_STRONG_MS   = 3'd3;
  localparam logic [2:0] REG_LOST_MS     = 3'd4;
  localparam logic [2:0] REG_BEEP_ON_MS  = 3'd5;
  localparam logic [2:0] REG_BEEP_OFF_MS = 3'd6;

  localparam logic [8:0] RST_OBSTACLE_CM = 9'd30;
  localparam logic [7:0] RST_GENTLE_MS   = 8'd12;
  localparam logic [7:0] RST_MEDIUM_MS   = 8'd22;
  localparam logic [7:0] RST_STRONG_MS   = 8'd38;
  localparam logic [7:0] RST_LOST_MS     = 8'd35;
  localparam logic [9:0] RST_BEEP_ON_MS  = 10'd200;
  localparam logic [9:0] RST_BEEP_OFF_MS = 10'd300;

  localparam logic [5:0] US_PER_CM   = 6'd58;
  localparam logic [9:0] ELAPSED_MAX = 10'd1023;

  // decision of the line rule for one sample
  typedef struct packed {
    drv_t        left;
    drv_t        right;
    logic [7:0]  hold;
    logic        fwd;
    logic        side_we;
    side_t       side;
  } line_dec_t;

  // hold times the line rule chooses from
  typedef struct packed {
    logic [7:0] gentle;
    logic [7:0] mid;
    logic [7:0] sharp;
    logic [7:0] lost;
  } hold_cfg_t;

  // one result item
  typedef struct packed {
    logic [1:0] left_drive;
    logic [1:0] right_drive;
    logic [7:0] hold_ms;
    logic       then_forward;
    logic       buzzer;
    logic       blocked;
    logic       active;
  } res_t;

endpackage

FILE: src/lfoc_line_rule.sv
module lfoc_line_rule (
  input  logic [4:0]         line_bits,
  input  lfoc_pkg::side_t    last_side,
  input  lfoc_pkg::hold_cfg_t holds,
  output lfoc_pkg::line_dec_t dec
);
  import lfoc_pkg::*;

  always_comb begin
    dec = '{left: DRV_FWD, right: DRV_FWD, hold: 8'd0, fwd: 1'b1,
            side_we: 1'b0, side: SIDE_CENTER};
    case (line_bits) inside
      5'h1F, 5'h04: begin
        dec.side_we = 1'b1;
        dec.side    = SIDE_CENTER;
      end
      5'h0C: begin
        dec = '{DRV_STOP, DRV_FWD, holds.gentle, 1'b1, 1'b1, SIDE_LEFT};
      end
      5'h08: begin
        dec = '{DRV_STOP, DRV_FWD, holds.mid, 1'b1, 1'b1, SIDE_LEFT};
      end
      5'h18, 5'h10: begin
        dec = '{DRV_BACK, DRV_FWD, holds.sharp, 1'b1, 1'b1, SIDE_LEFT};
      end
      5'h06: begin
        dec = '{DRV_FWD, DRV_STOP, holds.gentle, 1'b1, 1'b1, SIDE_RIGHT};
      end
      5'h02: begin
        dec = '{DRV_FWD, DRV_STOP, holds.mid, 1'b1, 1'b1, SIDE_RIGHT};
      end
      5'h03, 5'h01: begin
        dec = '{DRV_FWD, DRV_BACK, holds.sharp, 1'b1, 1'b1, SIDE_RIGHT};
      end
      default: begin
        if (line_bits[4] || line_bits[3]) begin
          dec = '{DRV_STOP, DRV_FWD, holds.mid, 1'b1, 1'b1, SIDE_LEFT};
        end else if (line_bits[1] || line_bits[0]) begin
          dec = '{DRV_FWD, DRV_STOP, holds.mid, 1'b1, 1'b1, SIDE_RIGHT};
        end else if (!line_bits[2]) begin
          // line lost: search toward the side seen last
          if (last_side == SIDE_LEFT) begin
            dec = '{DRV_STOP, DRV_FWD, holds.lost, 1'b0, 1'b0, SIDE_CENTER};
          end else if (last_side == SIDE_RIGHT) begin
            dec = '{DRV_FWD, DRV_STOP, holds.lost, 1'b0, 1'b0, SIDE_CENTER};
          end else begin
            dec = '{DRV_FWD, DRV_FWD, holds.lost, 1'b1, 1'b0, SIDE_CENTER};
          end
        end
      end
    endcase
  end

endmodule

FILE: src/line_follower_obstacle_controller.sv
// Line follower with obstacle stop: one result item for every input item.
// Results are registered. Throughput: one item per cycle while the skid
//   stage is empty; the state update for an item is one combinational
//   pass from the state registers to their next value.
// Reset (rst_n, synchronous, low): stopped, no obstacle, buzzer off,
//   registers back to their defaults, result and skid stages empty.
module line_follower_obstacle_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [4:0]  in_line_bits,
  input  logic [14:0] in_echo_us,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_left_drive,
  output logic [1:0]  out_right_drive,
  output logic [7:0]  out_hold_ms,
  output logic        out_then_forward,
  output logic        out_buzzer,
  output logic        out_blocked,
  output logic        out_active,
  // config bus
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lfoc_pkg::*;

  // ---------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------
  logic [8:0] obstacle_cm_r;
  logic [7:0] gentle_ms_r, medium_ms_r, strong_ms_r, lost_ms_r;
  logic [9:0] beep_on_ms_r, beep_off_ms_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_cm_r <= RST_OBSTACLE_CM;
      gentle_ms_r   <= RST_GENTLE_MS;
      medium_ms_r   <= RST_MEDIUM_MS;
      strong_ms_r   <= RST_STRONG_MS;
      lost_ms_r     <= RST_LOST_MS;
      beep_on_ms_r  <= RST_BEEP_ON_MS;
      beep_off_ms_r <= RST_BEEP_OFF_MS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OBSTACLE_CM: obstacle_cm_r <= pwdata[8:0];
        REG_GENTLE_MS:   gentle_ms_r   <= pwdata[7:0];
        REG_MEDIUM_MS:   medium_ms_r   <= pwdata[7:0];
        REG_STRONG_MS:   strong_ms_r   <= pwdata[7:0];
        REG_LOST_MS:     lost_ms_r     <= pwdata[7:0];
        REG_BEEP_ON_MS:  beep_on_ms_r  <= pwdata[9:0];
        REG_BEEP_OFF_MS: beep_off_ms_r <= pwdata[9:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OBSTACLE_CM: prdata = {23'd0, obstacle_cm_r};
      REG_GENTLE_MS:   prdata = {24'd0, gentle_ms_r};
      REG_MEDIUM_MS:   prdata = {24'd0, medium_ms_r};
      REG_STRONG_MS:   prdata = {24'd0, strong_ms_r};
      REG_LOST_MS:     prdata = {24'd0, lost_ms_r};
      REG_BEEP_ON_MS:  prdata = {22'd0, beep_on_ms_r};
      REG_BEEP_OFF_MS: prdata = {22'd0, beep_off_ms_r};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------
  logic       run_r, blk_r, seen_r, cw_r, lvl_r;
  side_t      side_r;
  logic [9:0] el_r;

  logic       run_nxt, blk_nxt, seen_nxt, cw_nxt, lvl_nxt;
  side_t      side_nxt;
  logic [9:0] el_nxt;

  logic       in_acc;
  res_t       res_new;

  // obstacle threshold in echo microseconds: 58 us per cm round trip,
  // 511 cm max still fits in 15 bits
  logic [14:0] echo_lim;
  assign echo_lim = 15'(obstacle_cm_r * US_PER_CM);

  line_dec_t dec;
  hold_cfg_t holds;
  assign holds = '{gentle: gentle_ms_r, mid: medium_ms_r,
                   sharp: strong_ms_r, lost: lost_ms_r};

  lfoc_line_rule u_rule (
    .line_bits (in_line_bits),
    .last_side (side_r),
    .holds     (holds),
    .dec       (dec)
  );

  // next state, evaluated in the same order as the command semantics:
  // command effect first, then the obstacle rule on the updated state
  always_comb begin
    logic [9:0] limit;
    run_nxt  = run_r;
    blk_nxt  = blk_r;
    seen_nxt = seen_r;
    cw_nxt   = cw_r;
    side_nxt = side_r;
    lvl_nxt  = lvl_r;
    el_nxt   = el_r;
    res_new  = '0;
    limit    = 10'd0;

    case (in_cmd)
      CMD_TICK: begin
        if (el_r != ELAPSED_MAX) el_nxt = el_r + 10'd1;
      end
      CMD_START: begin
        run_nxt  = 1'b1;
        blk_nxt  = 1'b0;
        side_nxt = SIDE_CENTER;
      end
      CMD_STOP: begin
        run_nxt = 1'b0;
        blk_nxt = 1'b0;
        cw_nxt  = 1'b0;
        lvl_nxt = 1'b0;
        el_nxt  = 10'd0;
      end
      CMD_LINE: begin
        if (run_r && !seen_r && !blk_r) begin
          res_new.left_drive   = dec.left;
          res_new.right_drive  = dec.right;
          res_new.hold_ms      = dec.hold;
          res_new.then_forward = dec.fwd;
          if (dec.side_we) side_nxt = dec.side;
        end
      end
      CMD_ECHO: begin
        seen_nxt = (in_echo_us != 15'd0) && (in_echo_us <= echo_lim);
        // two clear echoes in a row release the latch
        if (run_r && !seen_nxt && blk_r) begin
          if (cw_r) begin
            blk_nxt  = 1'b0;
            cw_nxt   = 1'b0;
            lvl_nxt  = 1'b0;
            el_nxt   = 10'd0;
            side_nxt = SIDE_CENTER;
          end else begin
            cw_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // obstacle in view while running: latch the stop and run the beeper
    if (run_nxt && seen_nxt) begin
      blk_nxt = 1'b1;
      cw_nxt  = 1'b0;
      limit   = lvl_nxt ? beep_on_ms_r : beep_off_ms_r;
      if (el_nxt >= limit) begin
        lvl_nxt = !lvl_nxt;
        el_nxt  = 10'd0;
      end
    end

    res_new.buzzer  = lvl_nxt;
    res_new.blocked = blk_nxt;
    res_new.active  = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      blk_r  <= 1'b0;
      seen_r <= 1'b0;
      cw_r   <= 1'b0;
      side_r <= SIDE_CENTER;
      lvl_r  <= 1'b0;
      el_r   <= 10'd0;
    end else if (in_acc) begin
      run_r  <= run_nxt;
      blk_r  <= blk_nxt;
      seen_r <= seen_nxt;
      cw_r   <= cw_nxt;
      side_r <= side_nxt;
      lvl_r  <= lvl_nxt;
      el_r   <= el_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Result register plus skid stage. in_stall comes straight from the
  // skid flag, so it never depends on out_stall in the same cycle.
  // ---------------------------------------------------------------
  res_t res_r, skid_r;
  logic out_valid_r, skid_valid_r;
  logic out_free;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      res_r <= skid_valid_r ? skid_r : res_new;
    end
    if (!out_free && in_acc) begin
      skid_r <= res_new;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_drive   = res_r.left_drive;
  assign out_right_drive  = res_r.right_drive;
  assign out_hold_ms      = res_r.hold_ms;
  assign out_then_forward = res_r.then_forward;
  assign out_buzzer       = res_r.buzzer;
  assign out_blocked      = res_r.blocked;
  assign out_active       = res_r.active;

endmodule

FILE: src/lfoc_checker.sv
module lfoc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_left_drive,
  input logic [1:0]  out_right_drive,
  input logic [7:0]  out_hold_ms,
  input logic        out_then_forward,
  input logic        out_buzzer,
  input logic        out_blocked,
  input logic        out_active
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_left_drive) && $stable(out_right_drive)
      && $stable(out_hold_ms) && $stable(out_then_forward) && $stable(out_buzzer)
      && $stable(out_blocked) && $stable(out_active))
    else $error("stalled result changed");

  // input backs up only when a result is waiting
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // the obstacle latch only exists while running
  a_block_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_blocked |-> out_active)
    else $error("blocked while stopped");

  // a blocked robot never gets a drive command
  a_block_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_blocked |-> out_left_drive == 2'd0 && out_right_drive == 2'd0
      && out_hold_ms == 8'd0 && !out_then_forward)
    else $error("drive issued while blocked");

endmodule

bind line_follower_obstacle_controller lfoc_checker u_lfoc_checker (.*);

FILE: bench/lfoc_check.sv
`timescale 1ns / 100ps

module lfoc_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [4:0]  in_line_bits,
  input  logic [14:0] in_echo_us,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_left_drive,
  input  logic [1:0]  out_right_drive,
  input  logic [7:0]  out_hold_ms,
  input  logic        out_then_forward,
  input  logic        out_buzzer,
  input  logic        out_blocked,
  input  logic        out_active,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding
);
  import lfoc_pkg::*;

  // register copy
  logic [8:0] cm_limit;
  logic [7:0] gentle_hold, medium_hold, strong_hold, lost_hold;
  logic [9:0] on_ms, off_ms;

  // controller state copy
  logic       running, latched, obstacle_seen, clear_once, beep;
  side_t      side;
  logic [9:0] elapsed;

  res_t status_q[$];

  function automatic res_t motion(input drv_t l, input drv_t r, input logic [7:0] hold,
                                  input logic fwd);
    res_t m;
    m = '0;
    m.left_drive   = l;
    m.right_drive  = r;
    m.hold_ms      = hold;
    m.then_forward = fwd;
    return m;
  endfunction

  // line rule; also updates the remembered side
  function automatic res_t steer(input logic [4:0] bits);
    res_t m;
    case (bits)
      5'h1F, 5'h04: begin
        side = SIDE_CENTER;
        m = motion(DRV_FWD, DRV_FWD, 8'd0, 1'b1);
      end
      5'h0C: begin
        side = SIDE_LEFT;
        m = motion(DRV_STOP, DRV_FWD, gentle_hold, 1'b1);
      end
      5'h08: begin
        side = SIDE_LEFT;
        m = motion(DRV_STOP, DRV_FWD, medium_hold, 1'b1);
      end
      5'h18, 5'h10: begin
        side = SIDE_LEFT;
        m = motion(DRV_BACK, DRV_FWD, strong_hold, 1'b1);
      end
      5'h06: begin
        side = SIDE_RIGHT;
        m = motion(DRV_FWD, DRV_STOP, gentle_hold, 1'b1);
      end
      5'h02: begin
        side = SIDE_RIGHT;
        m = motion(DRV_FWD, DRV_STOP, medium_hold, 1'b1);
      end
      5'h03, 5'h01: begin
        side = SIDE_RIGHT;
        m = motion(DRV_FWD, DRV_BACK, strong_hold, 1'b1);
      end
      default: begin
        if (bits[4] || bits[3]) begin
          side = SIDE_LEFT;
          m = motion(DRV_STOP, DRV_FWD, medium_hold, 1'b1);
        end else if (bits[1] || bits[0]) begin
          side = SIDE_RIGHT;
          m = motion(DRV_FWD, DRV_STOP, medium_hold, 1'b1);
        end else if (!bits[2]) begin
          // line lost: search toward the last side seen
          case (side)
            SIDE_LEFT:  m = motion(DRV_STOP, DRV_FWD, lost_hold, 1'b0);
            SIDE_RIGHT: m = motion(DRV_FWD, DRV_STOP, lost_hold, 1'b0);
            default:    m = motion(DRV_FWD, DRV_FWD, lost_hold, 1'b1);
          endcase
        end else begin
          m = motion(DRV_FWD, DRV_FWD, 8'd0, 1'b1);
        end
      end
    endcase
    return m;
  endfunction

  task automatic controller_step(input logic [2:0] cmd, input logic [4:0] bits,
                                 input logic [14:0] echo, output res_t r);
    int unsigned reach;
    reach = int'(US_PER_CM) * int'(cm_limit);
    r = motion(DRV_STOP, DRV_STOP, 8'd0, 1'b0);
    case (cmd)
      CMD_TICK: begin
        if (elapsed != ELAPSED_MAX) elapsed++;
      end
      CMD_START: begin
        running = 1'b1;
        latched = 1'b0;
        side    = SIDE_CENTER;
      end
      CMD_STOP: begin
        running    = 1'b0;
        latched    = 1'b0;
        clear_once = 1'b0;
        beep       = 1'b0;
        elapsed    = '0;
      end
      CMD_LINE: begin
        if (running && !obstacle_seen && !latched) r = steer(bits);
      end
      CMD_ECHO: begin
        obstacle_seen = (echo != 0) && (echo <= reach);
        if (running && !obstacle_seen && latched) begin
          if (clear_once) begin
            latched    = 1'b0;
            clear_once = 1'b0;
            beep       = 1'b0;
            elapsed    = '0;
            side       = SIDE_CENTER;
          end else begin
            clear_once = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (running && obstacle_seen) begin
      latched    = 1'b1;
      clear_once = 1'b0;
      if (elapsed >= (beep ? on_ms : off_ms)) begin
        beep    = !beep;
        elapsed = '0;
      end
    end
    r.buzzer  = beep;
    r.blocked = latched;
    r.active  = running;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : track
    res_t want, got;
    if (!rst_n) begin
      cm_limit      = RST_OBSTACLE_CM;
      gentle_hold   = RST_GENTLE_MS;
      medium_hold   = RST_MEDIUM_MS;
      strong_hold   = RST_STRONG_MS;
      lost_hold     = RST_LOST_MS;
      on_ms         = RST_BEEP_ON_MS;
      off_ms        = RST_BEEP_OFF_MS;
      running       = 1'b0;
      latched       = 1'b0;
      obstacle_seen = 1'b0;
      clear_once    = 1'b0;
      beep          = 1'b0;
      side          = SIDE_CENTER;
      elapsed       = '0;
      status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_OBSTACLE_CM: cm_limit    = pwdata[8:0];
          REG_GENTLE_MS:   gentle_hold = pwdata[7:0];
          REG_MEDIUM_MS:   medium_hold = pwdata[7:0];
          REG_STRONG_MS:   strong_hold = pwdata[7:0];
          REG_LOST_MS:     lost_hold   = pwdata[7:0];
          REG_BEEP_ON_MS:  on_ms       = pwdata[9:0];
          REG_BEEP_OFF_MS: off_ms      = pwdata[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_left_drive, out_right_drive, out_hold_ms, out_then_forward,
               out_buzzer, out_blocked, out_active};
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %h", $time, got);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          check_field("left_drive", int'(want.left_drive), int'(got.left_drive));
          check_field("right_drive", int'(want.right_drive), int'(got.right_drive));
          check_field("hold_ms", int'(want.hold_ms), int'(got.hold_ms));
          check_field("then_forward", int'(want.then_forward), int'(got.then_forward));
          check_field("buzzer", int'(want.buzzer), int'(got.buzzer));
          check_field("blocked", int'(want.blocked), int'(got.blocked));
          check_field("active", int'(want.active), int'(got.active));
        end
      end
      if (in_valid && !in_stall) begin
        controller_step(in_cmd, in_line_bits, in_echo_us, want);
        status_q.push_back(want);
      end
    end
    outstanding <= status_q.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import lfoc_pkg::*;

  // generous bound on the length of a correct run
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic [4:0]  in_line_bits = '0;
  logic [14:0] in_echo_us = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_left_drive;
  logic [1:0]  out_right_drive;
  logic [7:0]  out_hold_ms;
  logic        out_then_forward;
  logic        out_buzzer;
  logic        out_blocked;
  logic        out_active;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;

  // idle rates in percent, changed per phase
  int          sender_idle_pct = 0;
  int          stall_pct = 0;

  // threshold currently programmed, so echoes can be aimed around it
  logic [8:0]  cur_cm = RST_OBSTACLE_CM;

  line_follower_obstacle_controller DUT (.*);

  lfoc_check check_u (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver side: random stall at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("line_follower_obstacle_controller regression: fail");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it. Valid stays high
  // after acceptance so back-to-back items never toggle it within a step.
  task automatic send_item(input logic [2:0] cmd, input logic [4:0] bits,
                           input logic [14:0] echo);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_line_bits <= bits;
    in_echo_us   <= echo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result has come back.
  // The extra edge first lets the last accepted item reach the checker.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // bus write: setup, then access, then the bus goes quiet
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [8:0] cm, input logic [7:0] g_hold,
                           input logic [7:0] m_hold, input logic [7:0] s_hold,
                           input logic [7:0] l_hold, input logic [9:0] on_time,
                           input logic [9:0] off_time);
    write_reg(REG_OBSTACLE_CM, 32'(cm));
    write_reg(REG_GENTLE_MS, 32'(g_hold));
    write_reg(REG_MEDIUM_MS, 32'(m_hold));
    write_reg(REG_STRONG_MS, 32'(s_hold));
    write_reg(REG_LOST_MS, 32'(l_hold));
    write_reg(REG_BEEP_ON_MS, 32'(on_time));
    write_reg(REG_BEEP_OFF_MS, 32'(off_time));
    cur_cm = cm;
  endtask

  // One random item. The mix keeps the robot running most of the time so
  // obstacle latch / two-echo clear / beep toggling get exercised; unused
  // payload fields carry random bits too.
  task automatic random_item();
    int unsigned pick, reach;
    logic [2:0]  cmd;
    logic [4:0]  bits;
    logic [14:0] echo;
    reach = int'(US_PER_CM) * int'(cur_cm);
    bits  = 5'($urandom);
    echo  = 15'($urandom);
    pick  = $urandom_range(99);
    if (pick < 30) cmd = CMD_TICK;
    else if (pick < 34) cmd = CMD_START;
    else if (pick < 36) cmd = CMD_STOP;
    else if (pick < 66) cmd = CMD_LINE;
    else if (pick < 97) cmd = CMD_ECHO;
    else cmd = 3'($urandom_range(7, CMD_ECHO + 1));  // undefined codes

    if (cmd == CMD_LINE && $urandom_range(9) < 6) begin
      // favor the patterns the line rule names explicitly
      case ($urandom_range(10))
        0:  bits = 5'h1F;
        1:  bits = 5'h04;
        2:  bits = 5'h0C;
        3:  bits = 5'h08;
        4:  bits = 5'h18;
        5:  bits = 5'h10;
        6:  bits = 5'h06;
        7:  bits = 5'h02;
        8:  bits = 5'h03;
        9:  bits = 5'h01;
        default: bits = 5'h00;
      endcase
    end

    if (cmd == CMD_ECHO) begin
      pick = $urandom_range(99);
      if (pick < 10) echo = '0;
      else if (pick < 45) echo = 15'($urandom_range(reach, 1));
      else if (pick < 55) echo = 15'(reach + $urandom_range(1));  // right at the threshold
      else echo = 15'($urandom_range(32767, reach + 1));
    end
    send_item(cmd, bits, echo);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset register values (threshold 30 cm = 1740 us)
    send_item(CMD_LINE, 5'h1F, 15'd0);        // sample while stopped: no drive
    send_item(CMD_TICK, 5'h00, 15'h7FFF);
    send_item(CMD_ECHO, 5'h00, 15'd1);        // echo while stopped: only remembered
    send_item(CMD_START, 5'h1F, 15'd0);       // start with obstacle pending latches
    send_item(CMD_LINE, 5'h04, 15'd0);        // sample while blocked: no drive
    send_item(CMD_ECHO, 5'h00, 15'd1741);     // first clear echo
    send_item(CMD_ECHO, 5'h00, 15'h7FFF);     // second clear echo releases
    send_item(CMD_LINE, 5'h04, 15'd0);        // centered
    send_item(CMD_LINE, 5'h0C, 15'd0);        // gentle left
    send_item(CMD_LINE, 5'h08, 15'd0);        // medium left
    send_item(CMD_LINE, 5'h18, 15'd0);        // strong left
    send_item(CMD_LINE, 5'h10, 15'd0);
    send_item(CMD_LINE, 5'h06, 15'd0);        // gentle right
    send_item(CMD_LINE, 5'h02, 15'd0);        // medium right
    send_item(CMD_LINE, 5'h03, 15'd0);        // strong right
    send_item(CMD_LINE, 5'h01, 15'd0);
    send_item(CMD_LINE, 5'h00, 15'd0);        // lost line, last side right
    send_item(CMD_LINE, 5'h11, 15'd0);        // odd pattern, outer left wins
    send_item(CMD_LINE, 5'h00, 15'd0);        // lost line, last side left
    send_item(CMD_LINE, 5'h05, 15'd0);        // odd pattern, right side
    send_item(CMD_START, 5'h00, 15'd0);       // start forgets the side
    send_item(CMD_LINE, 5'h00, 15'd0);        // lost line, centered search
    send_item(CMD_ECHO, 5'h1F, 15'd1740);     // exactly at threshold: obstacle
    send_item(CMD_ECHO, 5'h00, 15'd0);        // no echo counts as clear
    send_item(CMD_ECHO, 5'h00, 15'd5);        // obstacle again cancels the clear
    send_item(CMD_STOP, 5'h00, 15'd0);
    send_item(3'd7, 5'h1F, 15'h7FFF);         // undefined code
    drain_results();

    // ---- low extremes, sender idling
    configure(9'd1, 8'd0, 8'd255, 8'd0, 8'd255, 10'd1, 10'd1);
    sender_idle_pct = 49;
    stall_pct       = 0;
    repeat (150) random_item();
    drain_results();

    // ---- high extremes, receiver stalling; a run of ticks ahead of the
    // obstacle, with the long beep times the buzzer stays off
    configure(9'd500, 8'd255, 8'd0, 8'd255, 8'd0, 10'd1000, 10'd1000);
    sender_idle_pct = 0;
    stall_pct       = 49;
    send_item(CMD_STOP, 5'h00, 15'd0);
    send_item(CMD_ECHO, 5'h00, 15'd0);
    send_item(CMD_START, 5'h00, 15'd0);
    repeat (60) send_item(CMD_TICK, 5'($urandom), 15'($urandom));
    send_item(CMD_ECHO, 5'h00, 15'd1);
    repeat (150) random_item();
    drain_results();

    // ---- random settings, both sides idling; sender waits out all
    // results once in the middle
    configure(9'($urandom_range(500, 1)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 10'($urandom_range(6, 1)),
              10'($urandom_range(6, 1)));
    sender_idle_pct = 14;
    stall_pct       = 14;
    repeat (80) random_item();
    drain_results();
    repeat (70) random_item();
    drain_results();

    // ---- random settings, no idling
    configure(9'($urandom_range(500, 1)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 10'($urandom_range(20, 1)),
              10'($urandom_range(20, 1)));
    sender_idle_pct = 0;
    stall_pct       = 0;
    repeat (150) random_item();
    drain_results();

    // quiet edges at the end catch any stray result
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("line_follower_obstacle_controller regression: pass");
    end else begin
      $display("line_follower_obstacle_controller regression: fail");
    end
    $finish;
  end

endmodule

FILE: line_follower_obstacle_controller.f
src/lfoc_pkg.sv
src/lfoc_line_rule.sv
src/line_follower_obstacle_controller.sv
src/lfoc_checker.sv
bench/lfoc_check.sv
bench/tb.sv
